>>> hdl/pnod_pkg.sv
// Shared types, constants, saturating helpers and the back-end micro-program.
package pnod_pkg;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic signed [63:0] vel_z;
  } request_t;

  typedef struct packed {
    logic signed [63:0] dpos_x;
    logic signed [63:0] dpos_y;
    logic signed [63:0] dpos_z;
    logic signed [63:0] accel_x;
    logic signed [63:0] accel_y;
    logic signed [63:0] accel_z;
    logic               fault;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     zero_pos;
  } qentry_t;

  typedef struct packed {
    logic [63:0] v;
    logic        sat;
  } sat_t;

  localparam logic [7:0] CFG_CENTRAL_MASS = 8'd0;
  localparam logic [7:0] CFG_PN_TERM_MASK = 8'd1;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  localparam int SLOTS     = 32;
  localparam int PROG_LEN  = 59;
  localparam int QDEPTH    = 2;

  // Scratch slots; the first six name the fields of the current request.
  localparam logic [4:0] S_P0   = 5'd0;
  localparam logic [4:0] S_P1   = 5'd1;
  localparam logic [4:0] S_P2   = 5'd2;
  localparam logic [4:0] S_V0   = 5'd3;
  localparam logic [4:0] S_V1   = 5'd4;
  localparam logic [4:0] S_V2   = 5'd5;
  localparam logic [4:0] NUM_ITEM_SLOTS = 5'd6;
  localparam logic [4:0] S_RDOT = 5'd6;
  localparam logic [4:0] S_VSQR = 5'd7;
  localparam logic [4:0] S_MR   = 5'd8;
  localparam logic [4:0] S_F    = 5'd9;
  localparam logic [4:0] S_RD2  = 5'd10;
  localparam logic [4:0] S_MR2  = 5'd11;
  localparam logic [4:0] S_MR3  = 5'd12;
  localparam logic [4:0] S_A    = 5'd13;
  localparam logic [4:0] S_B    = 5'd14;
  localparam logic [4:0] S_T1   = 5'd15;
  localparam logic [4:0] S_T2   = 5'd16;
  localparam logic [4:0] S_ACC0 = 5'd29;
  localparam logic [4:0] S_ACC1 = 5'd30;
  localparam logic [4:0] S_ACC2 = 5'd31;

  typedef enum logic [3:0] {
    OP_SQR_R, OP_SQR_V, OP_DOT, OP_SQRT, OP_RDOT, OP_VSQR, OP_DIVM,
    OP_DIV, OP_MUL, OP_MULR, OP_ADD, OP_MOVK, OP_END
  } op_e;

  typedef enum logic [1:0] {C_ALWAYS, C_1PN, C_2PN, C_3PN} cond_e;

  typedef enum logic [2:0] {
    B_IDLE, B_FETCH, B_EXEC, B_WAIT_MUL, B_WAIT_DIV
  } back_state_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [4:0]        dst;
    logic [4:0]        srca;
    logic [4:0]        srcb;
    logic              bimm;
    logic              nega;
    logic signed [5:0] k;
  } uop_t;

  function automatic uop_t u(op_e op, cond_e c, logic [4:0] d, logic [4:0] a,
                             logic [4:0] b, logic bi, logic ng, logic signed [5:0] k);
    uop_t r;
    r.op = op; r.cond = c; r.dst = d; r.srca = a; r.srcb = b;
    r.bimm = bi; r.nega = ng; r.k = k;
    return r;
  endfunction

  function automatic uop_t program_rom(logic [5:0] pc);
    uop_t r;
    r = u(OP_END, C_ALWAYS, '0, '0, '0, 1'b0, 1'b0, 6'sd0);
    case (pc)
      6'd0:  r = u(OP_SQR_R, C_ALWAYS, '0, S_P0, '0, 1'b0, 1'b0, 6'sd0);
      6'd1:  r = u(OP_SQR_R, C_ALWAYS, '0, S_P1, '0, 1'b0, 1'b0, 6'sd0);
      6'd2:  r = u(OP_SQR_R, C_ALWAYS, '0, S_P2, '0, 1'b0, 1'b0, 6'sd0);
      6'd3:  r = u(OP_SQR_V, C_ALWAYS, '0, S_V0, '0, 1'b0, 1'b0, 6'sd0);
      6'd4:  r = u(OP_SQR_V, C_ALWAYS, '0, S_V1, '0, 1'b0, 1'b0, 6'sd0);
      6'd5:  r = u(OP_SQR_V, C_ALWAYS, '0, S_V2, '0, 1'b0, 1'b0, 6'sd0);
      6'd6:  r = u(OP_DOT, C_ALWAYS, '0, S_P0, S_V0, 1'b0, 1'b0, 6'sd0);
      6'd7:  r = u(OP_DOT, C_ALWAYS, '0, S_P1, S_V1, 1'b0, 1'b0, 6'sd0);
      6'd8:  r = u(OP_DOT, C_ALWAYS, '0, S_P2, S_V2, 1'b0, 1'b0, 6'sd0);
      6'd9:  r = u(OP_SQRT, C_ALWAYS, '0, '0, '0, 1'b0, 1'b0, 6'sd0);
      6'd10: r = u(OP_RDOT, C_ALWAYS, S_RDOT, '0, '0, 1'b0, 1'b0, 6'sd0);
      6'd11: r = u(OP_VSQR, C_ALWAYS, S_VSQR, '0, '0, 1'b0, 1'b0, 6'sd0);
      6'd12: r = u(OP_DIVM, C_ALWAYS, S_MR, '0, '0, 1'b0, 1'b0, 6'sd0);
      6'd13: r = u(OP_DIV, C_ALWAYS, S_T1, S_MR, '0, 1'b0, 1'b0, 6'sd0);
      6'd14: r = u(OP_DIV, C_ALWAYS, S_F, S_T1, '0, 1'b0, 1'b0, 6'sd0);
      6'd15: r = u(OP_MUL, C_ALWAYS, S_RD2, S_RDOT, S_RDOT, 1'b0, 1'b0, 6'sd0);
      6'd16: r = u(OP_MUL, C_ALWAYS, S_MR2, S_MR, S_MR, 1'b0, 1'b0, 6'sd0);
      6'd17: r = u(OP_MUL, C_ALWAYS, S_MR3, S_MR2, S_MR, 1'b0, 1'b0, 6'sd0);
      6'd18: r = u(OP_MOVK, C_ALWAYS, S_A, '0, '0, 1'b1, 1'b0, 6'sd0);
      6'd19: r = u(OP_MOVK, C_ALWAYS, S_B, '0, '0, 1'b1, 1'b0, 6'sd0);
      6'd20: r = u(OP_MUL, C_1PN, S_T1, S_MR, '0, 1'b1, 1'b0, -6'sd4);
      6'd21: r = u(OP_ADD, C_1PN, S_T1, S_VSQR, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd22: r = u(OP_ADD, C_1PN, S_A, S_A, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd23: r = u(OP_MUL, C_1PN, S_T1, S_RDOT, '0, 1'b1, 1'b0, -6'sd4);
      6'd24: r = u(OP_ADD, C_1PN, S_B, S_B, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd25: r = u(OP_MUL, C_2PN, S_T1, S_RD2, '0, 1'b1, 1'b0, -6'sd2);
      6'd26: r = u(OP_MUL, C_2PN, S_T2, S_MR, '0, 1'b1, 1'b0, 6'sd9);
      6'd27: r = u(OP_ADD, C_2PN, S_T1, S_T1, S_T2, 1'b0, 1'b0, 6'sd0);
      6'd28: r = u(OP_MUL, C_2PN, S_T1, S_MR, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd29: r = u(OP_ADD, C_2PN, S_A, S_A, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd30: r = u(OP_MUL, C_2PN, S_T1, S_MR, '0, 1'b1, 1'b0, 6'sd2);
      6'd31: r = u(OP_MUL, C_2PN, S_T1, S_T1, S_RDOT, 1'b0, 1'b0, 6'sd0);
      6'd32: r = u(OP_ADD, C_2PN, S_B, S_B, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd33: r = u(OP_MUL, C_3PN, S_T1, S_MR3, '0, 1'b1, 1'b0, -6'sd16);
      6'd34: r = u(OP_MUL, C_3PN, S_T2, S_RD2, S_MR2, 1'b0, 1'b0, 6'sd0);
      6'd35: r = u(OP_ADD, C_3PN, S_T1, S_T1, S_T2, 1'b0, 1'b0, 6'sd0);
      6'd36: r = u(OP_ADD, C_3PN, S_A, S_A, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd37: r = u(OP_MUL, C_3PN, S_T1, S_RDOT, '0, 1'b1, 1'b0, -6'sd4);
      6'd38: r = u(OP_MUL, C_3PN, S_T1, S_T1, S_MR2, 1'b0, 1'b0, 6'sd0);
      6'd39: r = u(OP_ADD, C_3PN, S_B, S_B, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd40: r = u(OP_MUL, C_ALWAYS, S_T1, S_B, S_V0, 1'b0, 1'b0, 6'sd0);
      6'd41: r = u(OP_MULR, C_ALWAYS, S_T1, S_T1, '0, 1'b0, 1'b0, 6'sd0);
      6'd42: r = u(OP_MUL, C_ALWAYS, S_T2, S_A, S_P0, 1'b0, 1'b0, 6'sd0);
      6'd43: r = u(OP_ADD, C_ALWAYS, S_T2, S_P0, S_T2, 1'b0, 1'b0, 6'sd0);
      6'd44: r = u(OP_ADD, C_ALWAYS, S_T2, S_T2, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd45: r = u(OP_MUL, C_ALWAYS, S_ACC0, S_F, S_T2, 1'b0, 1'b1, 6'sd0);
      6'd46: r = u(OP_MUL, C_ALWAYS, S_T1, S_B, S_V1, 1'b0, 1'b0, 6'sd0);
      6'd47: r = u(OP_MULR, C_ALWAYS, S_T1, S_T1, '0, 1'b0, 1'b0, 6'sd0);
      6'd48: r = u(OP_MUL, C_ALWAYS, S_T2, S_A, S_P1, 1'b0, 1'b0, 6'sd0);
      6'd49: r = u(OP_ADD, C_ALWAYS, S_T2, S_P1, S_T2, 1'b0, 1'b0, 6'sd0);
      6'd50: r = u(OP_ADD, C_ALWAYS, S_T2, S_T2, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd51: r = u(OP_MUL, C_ALWAYS, S_ACC1, S_F, S_T2, 1'b0, 1'b1, 6'sd0);
      6'd52: r = u(OP_MUL, C_ALWAYS, S_T1, S_B, S_V2, 1'b0, 1'b0, 6'sd0);
      6'd53: r = u(OP_MULR, C_ALWAYS, S_T1, S_T1, '0, 1'b0, 1'b0, 6'sd0);
      6'd54: r = u(OP_MUL, C_ALWAYS, S_T2, S_A, S_P2, 1'b0, 1'b0, 6'sd0);
      6'd55: r = u(OP_ADD, C_ALWAYS, S_T2, S_P2, S_T2, 1'b0, 1'b0, 6'sd0);
      6'd56: r = u(OP_ADD, C_ALWAYS, S_T2, S_T2, S_T1, 1'b0, 1'b0, 6'sd0);
      6'd57: r = u(OP_MUL, C_ALWAYS, S_ACC2, S_F, S_T2, 1'b0, 1'b1, 6'sd0);
      default: r = u(OP_END, C_ALWAYS, '0, '0, '0, 1'b0, 1'b0, 6'sd0);
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // Saturate a magnitude with a sign into the signed 64-bit range.
  function automatic sat_t pack(logic neg, logic [127:0] m);
    sat_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (m > {64'd0, Q_MAX}) begin
        r.v = Q_MAX; r.sat = 1'b1;
      end else begin
        r.v = m[63:0];
      end
    end else begin
      if (m > {64'd0, Q_MIN}) begin
        r.v = Q_MIN; r.sat = 1'b1;
      end else begin
        r.v = 64'd0 - m[63:0];
      end
    end
    return r;
  endfunction

  function automatic sat_t sadd(logic [63:0] a, logic [63:0] b);
    sat_t        r;
    logic [63:0] s;
    s = a + b;
    r.v = s;
    r.sat = 1'b0;
    if (!a[63] && !b[63] && s[63]) begin
      r.v = Q_MAX; r.sat = 1'b1;
    end else if (a[63] && b[63] && !s[63]) begin
      r.v = Q_MIN; r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> hdl/pnod_front.sv
// Front end: takes requests and flags those whose position is exactly zero.
module pnod_front import pnod_pkg::*; (
  input  logic     start,
  input  logic     full,
  input  request_t request,
  output logic     busy,
  output logic     push,
  output qentry_t  entry
);

  assign busy = full;
  assign push = start && !full;

  // A zero position means a zero radius; the back end skips all arithmetic for it.
  always_comb begin
    entry.req      = request;
    entry.zero_pos = (request.pos_x == '0) && (request.pos_y == '0) &&
                     (request.pos_z == '0);
  end

endmodule

>>> hdl/pnod_queue.sv
// Two-entry request queue between the front end and the back end.
module pnod_queue import pnod_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t din,
  input  logic    pop,
  output qentry_t dout,
  output logic    full,
  output logic    empty
);

  qentry_t    entries [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(QDEPTH));
  assign empty = (count == 2'd0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= 2'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

>>> hdl/pnod_mul.sv
// Unsigned 64x64 multiplier built from one 32x32 multiplier over four passes.
module pnod_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   cnt;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic         pp_valid;
  logic         pp_last;
  logic [31:0]  ah;
  logic [31:0]  bh;
  logic [127:0] pp_wide;

  assign ah = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign bh = cnt[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (sh)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= 3'd0;
      pp_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 3'd0;
        pp_valid <= 1'b0;
      end else if (busy) begin
        if (!cnt[2]) begin
          pp_valid <= 1'b1;
          cnt      <= cnt + 3'd1;
        end else begin
          pp_valid <= 1'b0;
        end
        if (pp_valid && pp_last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial products are registered before they are added into the sum.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      if (!cnt[2]) begin
        pp      <= {32'd0, ah} * {32'd0, bh};
        sh      <= 2'({1'b0, cnt[1]} + {1'b0, cnt[0]});
        pp_last <= (cnt == 3'd3);
      end
      if (pp_valid) prod <= prod + pp_wide;
    end
  end

endmodule

>>> hdl/pnod_divsqrt.sv
// Serial unit: 128-by-64 restoring division or 128-bit integer square root.
module pnod_divsqrt (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         is_sqrt,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [127:0] quo
);

  logic [127:0] n_r;
  logic [63:0]  d_r;
  logic [65:0]  rem;
  logic         mode;
  logic         busy;
  logic [6:0]   cnt;
  logic [64:0]  dwide;
  logic         dge;
  logic [64:0]  dsub;
  logic [67:0]  swide;
  logic [67:0]  strial;
  logic         sge;
  logic [67:0]  ssub;

  assign dwide  = {rem[63:0], n_r[127]};
  assign dge    = dwide >= {1'b0, d_r};
  assign dsub   = dwide - {1'b0, d_r};
  assign swide  = {rem, n_r[127:126]};
  assign strial = {2'b00, quo[63:0], 2'b01};
  assign sge    = swide >= strial;
  assign ssub   = swide - strial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= is_sqrt ? 7'd63 : 7'd127;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r  <= num;
      d_r  <= den;
      rem  <= '0;
      quo  <= '0;
      mode <= is_sqrt;
    end else if (busy) begin
      if (mode) begin
        n_r <= {n_r[125:0], 2'b00};
        if (sge) begin
          rem <= ssub[65:0];
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= swide[65:0];
          quo <= {quo[126:0], 1'b0};
        end
      end else begin
        n_r <= {n_r[126:0], 1'b0};
        if (dge) begin
          rem <= {2'b00, dsub[63:0]};
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= {2'b00, dwide[63:0]};
          quo <= {quo[126:0], 1'b0};
        end
      end
    end
  end

endmodule

>>> hdl/pnod_back.sv
// Back end: micro-programmed sequencer that evaluates one request at a time.
module pnod_back import pnod_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  qentry_t     q_data,
  output logic        pop,
  input  logic [62:0] central_mass,
  input  logic [3:0]  pn_term_mask,
  output logic        done,
  output result_t     result
);

  back_state_e  state;
  back_state_e  state_next;
  logic [5:0]   pc;
  uop_t         op;
  request_t     item_r;
  logic [63:0]  mem [SLOTS];
  logic [63:0]  rda;
  logic [63:0]  rdb;
  logic [63:0]  opa;
  logic [63:0]  opb;
  logic [63:0]  kval;
  logic [63:0]  a_val;
  logic [63:0]  b_val;
  logic [127:0] acc_r;
  logic [127:0] acc_v;
  logic [127:0] pacc;
  logic [127:0] nacc;
  logic         dneg;
  logic [127:0] rdot_num;
  logic [63:0]  r_reg;
  logic [63:0]  accel [3];
  logic         fault_acc;
  logic         cond_ok;

  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_neg;
  logic         mul_done;
  logic [127:0] prod;
  logic         div_start;
  logic         div_sqrt;
  logic [127:0] div_num;
  logic         div_done;
  logic [127:0] quo;

  logic         wb_en;
  sat_t         wb;
  logic         pc_step;
  logic         finish;
  logic         zero_out;
  logic         acc_upd;
  logic         r_load;

  function automatic logic [63:0] item_field(request_t r, logic [4:0] s);
    unique case (s)
      S_P0:    return r.pos_x;
      S_P1:    return r.pos_y;
      S_P2:    return r.pos_z;
      S_V0:    return r.vel_x;
      S_V1:    return r.vel_y;
      default: return r.vel_z;
    endcase
  endfunction

  assign op   = program_rom(pc);
  assign opa  = (op.srca < NUM_ITEM_SLOTS) ? item_field(item_r, op.srca) : rda;
  assign opb  = (op.srcb < NUM_ITEM_SLOTS) ? item_field(item_r, op.srcb) : rdb;
  assign kval = {{58{op.k[5]}}, op.k} << FRAC_BITS;
  assign a_val = op.nega ? (64'd0 - opa) : opa;
  assign b_val = op.bimm ? kval : opb;

  assign dneg     = pacc < nacc;
  assign rdot_num = dneg ? (nacc - pacc) : (pacc - nacc);

  always_comb begin
    unique case (op.cond)
      C_ALWAYS: cond_ok = 1'b1;
      C_1PN:    cond_ok = pn_term_mask[0];
      C_2PN:    cond_ok = pn_term_mask[1];
      default:  cond_ok = pn_term_mask[3];
    endcase
  end

  always_comb begin
    unique case (op.op) inside
      OP_SQR_R, OP_SQR_V: begin
        mul_a = mag(opa); mul_b = mag(opa); mul_neg = 1'b0;
      end
      OP_DOT: begin
        mul_a = mag(opa); mul_b = mag(opb); mul_neg = opa[63] ^ opb[63];
      end
      OP_MULR: begin
        mul_a = mag(opa); mul_b = r_reg; mul_neg = opa[63];
      end
      default: begin
        mul_a = mag(a_val); mul_b = mag(b_val); mul_neg = a_val[63] ^ b_val[63];
      end
    endcase
  end

  pnod_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  pnod_divsqrt u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .is_sqrt (div_sqrt),
    .num     (div_num),
    .den     (r_reg),
    .done    (div_done),
    .quo     (quo)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (q_valid && !q_data.zero_pos) state_next = B_FETCH;
      B_FETCH:    state_next = B_EXEC;
      B_EXEC: begin
        if (mul_start) state_next = B_WAIT_MUL;
        else if (div_start) state_next = B_WAIT_DIV;
        else if (finish) state_next = B_IDLE;
        else state_next = B_FETCH;
      end
      B_WAIT_MUL: if (mul_done) state_next = B_FETCH;
      B_WAIT_DIV: if (div_done) state_next = B_FETCH;
      default:    state_next = B_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    zero_out  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    div_sqrt  = 1'b0;
    div_num   = '0;
    wb_en     = 1'b0;
    wb        = '0;
    pc_step   = 1'b0;
    finish    = 1'b0;
    acc_upd   = 1'b0;
    r_load    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          zero_out = q_data.zero_pos;
        end
      end
      B_EXEC: begin
        if (!cond_ok) begin
          pc_step = 1'b1;
        end else begin
          unique case (op.op) inside
            OP_SQR_R, OP_SQR_V, OP_DOT, OP_MUL, OP_MULR: mul_start = 1'b1;
            OP_SQRT: begin
              div_start = 1'b1; div_sqrt = 1'b1; div_num = acc_r;
            end
            OP_RDOT: begin
              div_start = 1'b1; div_num = rdot_num;
            end
            OP_DIVM: begin
              div_start = 1'b1; div_num = {65'd0, central_mass} << FRAC_BITS;
            end
            OP_DIV: begin
              div_start = 1'b1; div_num = {64'd0, opa} << FRAC_BITS;
            end
            OP_VSQR: begin
              wb_en = 1'b1; wb = pack(1'b0, acc_v >> FRAC_BITS); pc_step = 1'b1;
            end
            OP_ADD: begin
              wb_en = 1'b1; wb = sadd(opa, opb); pc_step = 1'b1;
            end
            OP_MOVK: begin
              wb_en = 1'b1; wb.v = kval; wb.sat = 1'b0; pc_step = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      B_WAIT_MUL: begin
        if (mul_done) begin
          pc_step = 1'b1;
          unique case (op.op) inside
            OP_SQR_R, OP_SQR_V, OP_DOT: acc_upd = 1'b1;
            default: begin
              wb_en = 1'b1; wb = pack(mul_neg, prod >> FRAC_BITS);
            end
          endcase
        end
      end
      B_WAIT_DIV: begin
        if (div_done) begin
          pc_step = 1'b1;
          unique case (op.op) inside
            OP_SQRT: r_load = 1'b1;
            OP_RDOT: begin
              wb_en = 1'b1; wb = pack(dneg, quo);
            end
            default: begin
              wb_en = 1'b1; wb = pack(1'b0, quo);
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      pc    <= 6'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish || (pop && zero_out);
      if (pop) pc <= 6'd0;
      else if (pc_step) pc <= pc + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) mem[op.dst] <= wb.v;
    rda <= mem[op.srca];
    rdb <= mem[op.srcb];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r    <= q_data.req;
      acc_r     <= '0;
      acc_v     <= '0;
      pacc      <= '0;
      nacc      <= '0;
      fault_acc <= 1'b0;
    end
    if (acc_upd) begin
      unique case (op.op) inside
        OP_SQR_R: acc_r <= acc_r + prod;
        OP_SQR_V: acc_v <= acc_v + prod;
        default: begin
          if (mul_neg) nacc <= nacc + prod;
          else pacc <= pacc + prod;
        end
      endcase
    end
    if (wb_en) begin
      fault_acc <= fault_acc | wb.sat;
      if (op.dst == S_ACC0) accel[0] <= wb.v;
      if (op.dst == S_ACC1) accel[1] <= wb.v;
      if (op.dst == S_ACC2) accel[2] <= wb.v;
    end
    if (r_load) r_reg <= quo[63:0];
    if (pop && zero_out) begin
      result.dpos_x  <= q_data.req.vel_x;
      result.dpos_y  <= q_data.req.vel_y;
      result.dpos_z  <= q_data.req.vel_z;
      result.accel_x <= '0;
      result.accel_y <= '0;
      result.accel_z <= '0;
      result.fault   <= 1'b1;
    end else if (finish) begin
      result.dpos_x  <= item_r.vel_x;
      result.dpos_y  <= item_r.vel_y;
      result.dpos_z  <= item_r.vel_z;
      result.accel_x <= accel[0];
      result.accel_y <= accel[1];
      result.accel_z <= accel[2];
      result.fault   <= fault_acc;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
      state != B_IDLE |-> pc < 6'(PROG_LEN))
    else $error("program counter ran past the end of the program");
  a_done_source: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(state == B_EXEC || state == B_IDLE))
    else $error("result issued outside the end step or the zero-radius path");
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
      state == B_WAIT_MUL && !mul_done |=> state == B_WAIT_MUL)
    else $error("left multiply wait before the product was ready");
`endif

endmodule

>>> hdl/post_newtonian_orbit_derivative.sv
// Top level: configuration registers, front end, request queue and back end.
// Each request is evaluated by a micro-programmed back end, whose run time is
// set by the serial 128-step divider (four divisions per request), the 64-step
// square root and the four-pass 64x64 multiplier. A request whose position is
// exactly zero gives its result in the cycle after the back end takes it from
// the queue, with a zero acceleration and fault set. Up to two requests wait in
// the queue while the back end works; busy is high while the queue is full.
// Each result is placed on result and marked by done, which is high for
// exactly one cycle; the result cannot be stalled.
module post_newtonian_orbit_derivative import pnod_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [62:0] central_mass;
  logic [3:0]  pn_term_mask;
  logic        push;
  qentry_t     entry;
  qentry_t     q_data;
  logic        full;
  logic        empty;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      central_mass <= 63'h1 << FRAC_BITS;
      pn_term_mask <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CENTRAL_MASS) central_mass <= cfg_data[62:0];
      else if (cfg_index == CFG_PN_TERM_MASK) pn_term_mask <= cfg_data[3:0];
    end
  end

  pnod_front u_front (
    .start   (start),
    .full    (full),
    .request (request),
    .busy    (busy),
    .push    (push),
    .entry   (entry)
  );

  pnod_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (q_data),
    .full  (full),
    .empty (empty)
  );

  pnod_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!empty),
    .q_data       (q_data),
    .pop          (pop),
    .central_mass (central_mass),
    .pn_term_mask (pn_term_mask),
    .done         (done),
    .result       (result)
  );

endmodule
